// ===== src/mte_pkg.sv =====
package mte_pkg;

  typedef enum logic [1:0] {
    SYM_DOT  = 2'd0,
    SYM_DASH = 2'd1,
    SYM_GAP  = 2'd2
  } symbol_e;

  localparam int unsigned CodeMax  = 6;
  localparam int unsigned LenW     = $clog2(CodeMax + 1);
  localparam int unsigned GapW     = 2;
  localparam int unsigned WordGap  = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // code bits are left aligned: bits[CodeMax-1] is sent first, 1 is a dash
  typedef struct packed {
    logic [LenW-1:0]    len;
    logic [CodeMax-1:0] bits;
  } morse_t;

  // one queue entry: separator gaps, then the code
  typedef struct packed {
    logic [GapW-1:0]    gaps;
    logic [LenW-1:0]    len;
    logic [CodeMax-1:0] bits;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic morse_t morse_of(input logic [7:0] c_in);
    logic [7:0] c;
    morse_t     m;
    c = c_in;
    if ((c >= 8'h61) && (c <= 8'h7a)) c = c - 8'h20;
    case (c)
      "A":     m = '{len: 3'd2, bits: 6'b010000};
      "B":     m = '{len: 3'd4, bits: 6'b100000};
      "C":     m = '{len: 3'd4, bits: 6'b101000};
      "D":     m = '{len: 3'd3, bits: 6'b100000};
      "E":     m = '{len: 3'd1, bits: 6'b000000};
      "F":     m = '{len: 3'd4, bits: 6'b001000};
      "G":     m = '{len: 3'd3, bits: 6'b110000};
      "H":     m = '{len: 3'd4, bits: 6'b000000};
      "I":     m = '{len: 3'd2, bits: 6'b000000};
      "J":     m = '{len: 3'd4, bits: 6'b011100};
      "K":     m = '{len: 3'd3, bits: 6'b101000};
      "L":     m = '{len: 3'd4, bits: 6'b010000};
      "M":     m = '{len: 3'd2, bits: 6'b110000};
      "N":     m = '{len: 3'd2, bits: 6'b100000};
      "O":     m = '{len: 3'd3, bits: 6'b111000};
      "P":     m = '{len: 3'd4, bits: 6'b011000};
      "Q":     m = '{len: 3'd4, bits: 6'b110100};
      "R":     m = '{len: 3'd3, bits: 6'b010000};
      "S":     m = '{len: 3'd3, bits: 6'b000000};
      "T":     m = '{len: 3'd1, bits: 6'b100000};
      "U":     m = '{len: 3'd3, bits: 6'b001000};
      "V":     m = '{len: 3'd4, bits: 6'b000100};
      "W":     m = '{len: 3'd3, bits: 6'b011000};
      "X":     m = '{len: 3'd4, bits: 6'b100100};
      "Y":     m = '{len: 3'd4, bits: 6'b101100};
      "Z":     m = '{len: 3'd4, bits: 6'b110000};
      "0":     m = '{len: 3'd5, bits: 6'b111110};
      "1":     m = '{len: 3'd5, bits: 6'b011110};
      "2":     m = '{len: 3'd5, bits: 6'b001110};
      "3":     m = '{len: 3'd5, bits: 6'b000110};
      "4":     m = '{len: 3'd5, bits: 6'b000010};
      "5":     m = '{len: 3'd5, bits: 6'b000000};
      "6":     m = '{len: 3'd5, bits: 6'b100000};
      "7":     m = '{len: 3'd5, bits: 6'b110000};
      "8":     m = '{len: 3'd5, bits: 6'b111000};
      "9":     m = '{len: 3'd5, bits: 6'b111100};
      "/":     m = '{len: 3'd5, bits: 6'b100100};
      "?":     m = '{len: 3'd6, bits: 6'b001100};
      ",":     m = '{len: 3'd6, bits: 6'b110011};
      ".":     m = '{len: 3'd6, bits: 6'b010101};
      "+":     m = '{len: 3'd5, bits: 6'b010100};
      "=":     m = '{len: 3'd5, bits: 6'b100010};
      default: m = '{len: '0, bits: '0};
    endcase
    return m;
  endfunction

endpackage

// ===== src/mte_front.sv =====
module mte_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  mte_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output mte_pkg::desc_t      push_desc_o
);
  import mte_pkg::*;

  logic   any_seen_q, any_seen_d;
  logic   prev_ws_q, prev_ws_d;
  logic   accept;
  logic   ws;
  morse_t code;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign ws         = is_space(char_code_i);
  assign code       = morse_of(char_code_i);

  always_comb begin
    if (prev_ws_q) begin
      push_desc_o.gaps = GapW'(WordGap);
    end else if (any_seen_q) begin
      push_desc_o.gaps = GapW'(1);
    end else begin
      push_desc_o.gaps = '0;
    end
    push_desc_o.len  = code.len;
    push_desc_o.bits = code.bits;
  end

  // words that cause no symbol never enter the queue
  assign push_o = accept && !ws && ((push_desc_o.gaps != '0) || (code.len != '0));

  always_comb begin
    any_seen_d = any_seen_q;
    prev_ws_d  = prev_ws_q;
    if (accept) begin
      any_seen_d = 1'b1;
      prev_ws_d  = ws;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_seen_q <= 1'b0;
      prev_ws_q  <= 1'b0;
    end else begin
      any_seen_q <= any_seen_d;
      prev_ws_q  <= prev_ws_d;
    end
  end

endmodule

// ===== src/mte_queue.sv =====
module mte_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mte_pkg::desc_t      push_desc_i,
  input  logic                pop_i,
  output mte_pkg::desc_t      pop_desc_o,
  output mte_pkg::q_status_t  status_o
);
  import mte_pkg::*;

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_desc_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCntW'(1)))
    else $error("queue count did not follow push");

endmodule

// ===== src/mte_back.sv =====
module mte_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mte_pkg::q_status_t  q_status_i,
  input  mte_pkg::desc_t      pop_desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          symbol_o,
  output logic                last_of_run_o
);
  import mte_pkg::*;

  logic               w_valid_q, w_valid_d;
  logic [GapW-1:0]    gaps_q, gaps_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [CodeMax-1:0] bits_q, bits_d;

  logic               out_valid_q, out_valid_d;
  symbol_e            sym_q, sym_d;
  logic               last_q, last_d;

  logic               adv;
  logic               is_last;
  symbol_e            cur_sym;

  assign adv     = w_valid_q && (!out_valid_q || out_ready_i);
  assign is_last = ((gaps_q == GapW'(1)) && (len_q == '0)) ||
                   ((gaps_q == '0) && (len_q == LenW'(1)));
  assign cur_sym = (gaps_q != '0) ? SYM_GAP :
                   (bits_q[CodeMax-1] ? SYM_DASH : SYM_DOT);

  assign pop_o = !q_status_i.empty && (!w_valid_q || (adv && is_last));

  always_comb begin
    w_valid_d = w_valid_q;
    gaps_d    = gaps_q;
    len_d     = len_q;
    bits_d    = bits_q;
    if (adv) begin
      if (is_last) begin
        w_valid_d = 1'b0;
      end else if (gaps_q != '0) begin
        gaps_d = gaps_q - GapW'(1);
      end else begin
        len_d  = len_q - LenW'(1);
        bits_d = {bits_q[CodeMax-2:0], 1'b0};
      end
    end
    if (pop_o) begin
      w_valid_d = 1'b1;
      gaps_d    = pop_desc_i.gaps;
      len_d     = pop_desc_i.len;
      bits_d    = pop_desc_i.bits;
    end
  end

  // output register parts the serializer from the consumer
  always_comb begin
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = 1'b1;
      sym_d       = cur_sym;
      last_d      = is_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      w_valid_q   <= w_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gaps_q <= gaps_d;
    len_q  <= len_d;
    bits_q <= bits_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = sym_q;
  assign last_of_run_o = last_q;

  a_work_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q |-> ((gaps_q != '0) || (len_q != '0)))
    else $error("serializer holds an empty word");

  a_gap_before_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (gaps_q != '0)) |=> (sym_q == SYM_GAP))
    else $error("separator gap not sent first");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q |-> (len_q <= LenW'(CodeMax)))
    else $error("code length out of range");

endmodule

// ===== src/morse_text_encoder_unit.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------
// input    | in_valid_i / in_ready_o    | char_code_i [7:0]
// output   | out_valid_o / out_ready_i  | symbol_o [1:0], last_of_run_o
//
// a word is taken on an input handshake and queued as a gap count plus its
// code; the serializer sends one symbol per cycle while the output is not
// stalled: 1 to 9 symbols per word, whitespace and an unknown first byte none
// reset clears the word-boundary state, the queue and the output register
// a stalled output holds its register; the two-entry queue then fills and
// in_ready_o drops
module morse_text_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] symbol_o,
  output logic       last_of_run_o
);
  import mte_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  desc_t     push_desc;
  desc_t     pop_desc;

  mte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  mte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc),
    .status_o    (q_status)
  );

  mte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .pop_desc_i    (pop_desc),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
